### src/chained_hash_key_value_table_macros.svh
// assertion macros for the chained hash key/value table
`ifndef CHAINED_HASH_KEY_VALUE_TABLE_MACROS_SVH
`define CHAINED_HASH_KEY_VALUE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define CHKVT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chkvt: same-cycle check failed");
`define CHKVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chkvt: next-cycle check failed");
`else
`define CHKVT_ASSERT_IMPLY(lbl, ante, cons)
`define CHKVT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/chkvt_pkg.sv
// shared constants, types and hash helpers of the chained hash table
package chkvt_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned BUCKETS     = 397;
  localparam int unsigned KEY_BYTES   = 4;
  localparam int unsigned SlotW       = $clog2(CAPACITY);
  localparam int unsigned LinkW       = SlotW + 1;
  localparam int unsigned BktW        = $clog2(BUCKETS);
  localparam logic [LinkW-1:0] NIL    = LinkW'(CAPACITY);

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3
  localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;

  typedef enum logic [1:0] {
    FUNC_INSERT,
    FUNC_REMOVE,
    FUNC_LOOKUP,
    FUNC_CLEAR
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [31:0]      key;
    logic [31:0]      value;
    logic [BktW-1:0]  bucket;
  } op_t;

  typedef struct packed {
    logic              found;
    logic [31:0]       value;
    logic              full_drop;
    logic [LinkW-1:0]  count;
  } res_t;

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x * FNV_PRIME_LO);
  endfunction

  // r = (r * 256 + b) mod BUCKETS, restoring steps on a narrow word
  function automatic logic [BktW-1:0] mod_step(input logic [BktW-1:0] r, input logic [7:0] b);
    logic [BktW+7:0] x;
    x = {r, b};
    for (int i = 7; i >= 0; i--) begin
      if (x >= ((BktW+8)'(BUCKETS) << i)) begin
        x = x - ((BktW+8)'(BUCKETS) << i);
      end
    end
    return x[BktW-1:0];
  endfunction

endpackage

### src/chained_hash_key_value_table.sv
// top level: queue-style key/value table with chained hash buckets
// an operation is hashed byte by byte and reduced to a bucket in the front end, then the back end
//   reads the bucket and walks its chain one link at a time; the front end takes no new operation
//   until its current one is queued, and a remove that relocates an entry adds a second walk
// clear all: one bucket per cycle over all 397 buckets before its result
// reset: async active low; a clearing pass over all 397 buckets follows, full stays high
module chained_hash_key_value_table import chkvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_in_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [31:0] value_out_o,
  output logic        full_drop_o,
  output logic [6:0]  entry_count_o
);

`include "chained_hash_key_value_table_macros.svh"

  op_t  fr_op;
  logic fr_valid, fr_ready;
  op_t  q_op;
  logic q_valid, q_ready;
  res_t bk_res;
  logic bk_valid, bk_ready;
  logic init_busy;

  // output register parts the result side from the back end
  logic out_valid_q;
  res_t out_q;

  // front end: hash the key and pick the bucket
  chkvt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .hold_i     (init_busy),
    .full_o     (full),
    .func_i     (func_i),
    .key_i      (key_i),
    .value_in_i (value_in_i),
    .op_o       (fr_op),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready)
  );

  // short queue so hashing and chain walks stall on their own
  chkvt_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wdata_i  (fr_op),
    .wvalid_i (fr_valid),
    .wready_o (fr_ready),
    .rdata_o  (q_op),
    .rvalid_o (q_valid),
    .rready_i (q_ready)
  );

  // back end: memories and chain updates
  chkvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (q_op),
    .op_valid_i  (q_valid),
    .op_ready_o  (q_ready),
    .res_o       (bk_res),
    .res_valid_o (bk_valid),
    .res_ready_i (bk_ready),
    .init_busy_o (init_busy)
  );

  assign bk_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (bk_ready) begin
      out_valid_q <= bk_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bk_ready && bk_valid) begin
      out_q <= bk_res;
    end
  end

  assign empty         = !out_valid_q;
  assign found_o       = out_q.found;
  assign value_out_o   = out_q.value;
  assign full_drop_o   = out_q.full_drop;
  assign entry_count_o = out_q.count;

  // a dropped insert only happens on a full table and a new key
  `CHKVT_ASSERT_IMPLY(a_drop_full, out_valid_q && out_q.full_drop,
                      !out_q.found && out_q.count == LinkW'(CAPACITY))
  // a nonzero value only comes from a hit
  `CHKVT_ASSERT_IMPLY(a_value_hit, out_valid_q && out_q.value != 32'd0, out_q.found)
  // a held result transfer keeps the back end waiting
  `CHKVT_ASSERT_NEXT(a_res_hold, bk_valid && !bk_ready, bk_valid && out_valid_q)

endmodule

### src/chkvt_front.sv
// front end: takes an operation, hashes the key and reduces it to a bucket
module chkvt_front import chkvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        hold_i,
  output logic        full_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_in_i,
  output op_t         op_o,
  output logic        op_valid_o,
  input  logic        op_ready_i
);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} fstate_e;

  fstate_e     state_q;
  logic [3:0]  cnt_q;
  logic [63:0] hash_q;
  logic [31:0] key_sh_q;
  op_t         op_q;

  assign full_o     = (state_q != F_IDLE) || hold_i;
  assign op_valid_o = (state_q == F_PUSH);
  assign op_o       = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push_i && !full_o) begin
            op_q.func  <= func_e'(func_i);
            op_q.key   <= key_i;
            op_q.value <= value_in_i;
            key_sh_q   <= key_i;
            hash_q     <= FNV_BASIS;
            cnt_q      <= '0;
            state_q    <= F_HASH;
          end
        end
        F_HASH: begin
          hash_q   <= fnv_step(hash_q, key_sh_q[7:0]);
          key_sh_q <= key_sh_q >> 8;
          cnt_q    <= cnt_q + 4'd1;
          if (cnt_q == 4'(KEY_BYTES - 1)) begin
            cnt_q       <= '0;
            op_q.bucket <= '0;
            state_q     <= F_MOD;
          end
        end
        F_MOD: begin
          // most significant byte first
          op_q.bucket <= mod_step(op_q.bucket, hash_q[63:56]);
          hash_q      <= hash_q << 8;
          cnt_q       <= cnt_q + 4'd1;
          if (cnt_q == 4'd7) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (op_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### src/chkvt_fifo.sv
// two-entry operation queue between front and back end
module chkvt_fifo import chkvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  wdata_i,
  input  logic wvalid_i,
  output logic wready_o,
  output op_t  rdata_o,
  output logic rvalid_o,
  input  logic rready_i
);

  op_t        mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;
  logic       do_wr;
  logic       do_rd;

  assign wready_o = (cnt_q != 2'd2);
  assign rvalid_o = (cnt_q != 2'd0);
  assign rdata_o  = mem_q[rptr_q];
  assign do_wr    = wvalid_i && wready_o;
  assign do_rd    = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### src/chkvt_back.sv
// back end: bucket and entry memories, chain walks and updates
module chkvt_back import chkvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  op_i,
  input  logic op_valid_i,
  output logic op_ready_o,
  output res_t res_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output logic init_busy_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BKT_RD, S_BKT_CAP, S_WALK, S_CMP, S_DECIDE, S_INS_LINK,
    S_MV_RD, S_MV_CAP, S_MV_BRD, S_MV_BCAP, S_FS_WALK, S_FS_NEXT, S_MV_FIX,
    S_MV_COPY_RESP
  } bstate_e;

  // memories
  logic [2*LinkW-1:0] bkt_mem [BUCKETS];
  logic [LinkW-1:0]   nxt_mem [CAPACITY];
  logic [31:0]        key_mem [CAPACITY];
  logic [31:0]        val_mem [CAPACITY];
  logic [BktW-1:0]    bid_mem [CAPACITY];

  logic               bkt_we;
  logic [BktW-1:0]    bkt_waddr;
  logic [2*LinkW-1:0] bkt_wdata;
  logic [BktW-1:0]    bkt_raddr;
  logic [2*LinkW-1:0] bkt_rdata_q;

  logic               nxt_we;
  logic [SlotW-1:0]   nxt_waddr;
  logic [LinkW-1:0]   nxt_wdata;
  logic               fld_we;
  logic               val_we;
  logic [SlotW-1:0]   ent_waddr;
  logic [31:0]        key_wdata;
  logic [31:0]        val_wdata;
  logic [BktW-1:0]    bid_wdata;
  logic [SlotW-1:0]   ent_raddr;
  logic [LinkW-1:0]   nxt_rdata_q;
  logic [31:0]        key_rdata_q;
  logic [31:0]        val_rdata_q;
  logic [BktW-1:0]    bid_rdata_q;

  // control and working registers
  bstate_e          state_q;
  logic             clr_op_q;
  logic [BktW-1:0]  clr_addr_q;
  logic [LinkW-1:0] count_q;
  op_t              op_q;
  logic [LinkW-1:0] head_q, tail_q, n_q, p_q, slot_q, prev_q, nx_q, steps_q;
  logic             found_q, drop_q, fs_hit_q;
  logic [31:0]      fval_q, lkey_q, lval_q;
  logic [LinkW-1:0] lnext_q;
  logic [BktW-1:0]  lb_q;
  logic             resp_q;

  logic [LinkW-1:0] last;
  logic             walk_ok;
  logic             tail_ok;

  assign last        = count_q - LinkW'(1);
  assign walk_ok     = (n_q < NIL) && (n_q < count_q) && (steps_q < LinkW'(CAPACITY));
  // tail link check against the count before the insert
  assign tail_ok     = (tail_q < NIL) && (tail_q < count_q);
  assign op_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = resp_q;
  assign init_busy_o = (state_q == S_CLEAR) && !clr_op_q;

  assign res_o = '{found: found_q, value: fval_q, full_drop: drop_q, count: count_q};

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = op_q.bucket;
    bkt_wdata = {NIL, NIL};
    bkt_raddr = op_q.bucket;
    nxt_we    = 1'b0;
    nxt_waddr = '0;
    nxt_wdata = NIL;
    fld_we    = 1'b0;
    val_we    = 1'b0;
    ent_waddr = slot_q[SlotW-1:0];
    key_wdata = op_q.key;
    val_wdata = op_q.value;
    bid_wdata = op_q.bucket;
    ent_raddr = n_q[SlotW-1:0];
    case (state_q)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_addr_q;
      end
      S_DECIDE: begin
        case (op_q.func)
          FUNC_INSERT: begin
            if (found_q) begin
              val_we = 1'b1;
            end else if (count_q < LinkW'(CAPACITY)) begin
              fld_we    = 1'b1;
              val_we    = 1'b1;
              ent_waddr = count_q[SlotW-1:0];
              nxt_we    = 1'b1;
              nxt_waddr = count_q[SlotW-1:0];
              nxt_wdata = NIL;
              bkt_we    = 1'b1;
              bkt_wdata = {(tail_ok ? head_q : count_q), count_q};
            end
          end
          FUNC_REMOVE: begin
            if (found_q) begin
              bkt_we    = 1'b1;
              bkt_wdata = {((prev_q == NIL) ? nx_q : head_q),
                           ((tail_q == slot_q) ? prev_q : tail_q)};
              nxt_we    = (prev_q != NIL);
              nxt_waddr = prev_q[SlotW-1:0];
              nxt_wdata = nx_q;
            end
          end
          default: ;
        endcase
      end
      S_INS_LINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_q[SlotW-1:0];
        nxt_wdata = slot_q;
      end
      S_MV_RD: begin
        ent_raddr = last[SlotW-1:0];
      end
      S_MV_BRD: begin
        bkt_raddr = lb_q;
      end
      S_MV_FIX: begin
        bkt_we    = 1'b1;
        bkt_waddr = lb_q;
        bkt_wdata = {((fs_hit_q && p_q == NIL) ? slot_q : head_q),
                     ((tail_q == last) ? slot_q : tail_q)};
        nxt_we    = fs_hit_q && (p_q != NIL);
        nxt_waddr = p_q[SlotW-1:0];
        nxt_wdata = slot_q;
      end
      S_MV_COPY_RESP: begin
        if (!resp_q) begin
          fld_we    = 1'b1;
          val_we    = 1'b1;
          key_wdata = lkey_q;
          val_wdata = lval_q;
          bid_wdata = lb_q;
          nxt_we    = 1'b1;
          nxt_waddr = slot_q[SlotW-1:0];
          nxt_wdata = lnext_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata_q <= bkt_mem[bkt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (fld_we) begin
      key_mem[ent_waddr] <= key_wdata;
      bid_mem[ent_waddr] <= bid_wdata;
    end
    if (val_we) begin
      val_mem[ent_waddr] <= val_wdata;
    end
    nxt_rdata_q <= nxt_mem[ent_raddr];
    key_rdata_q <= key_mem[ent_raddr];
    val_rdata_q <= val_mem[ent_raddr];
    bid_rdata_q <= bid_mem[ent_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_op_q   <= 1'b0;
      clr_addr_q <= '0;
      count_q    <= '0;
      resp_q     <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + BktW'(1);
          if (clr_addr_q == BktW'(BUCKETS - 1)) begin
            count_q <= '0;
            if (clr_op_q) begin
              resp_q  <= 1'b1;
              state_q <= S_MV_COPY_RESP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (op_valid_i) begin
            op_q    <= op_i;
            found_q <= 1'b0;
            drop_q  <= 1'b0;
            fval_q  <= '0;
            if (op_i.func == FUNC_CLEAR) begin
              clr_addr_q <= '0;
              clr_op_q   <= 1'b1;
              state_q    <= S_CLEAR;
            end else begin
              state_q <= S_BKT_RD;
            end
          end
        end
        S_BKT_RD: state_q <= S_BKT_CAP;
        S_BKT_CAP: begin
          head_q  <= bkt_rdata_q[2*LinkW-1:LinkW];
          tail_q  <= bkt_rdata_q[LinkW-1:0];
          n_q     <= bkt_rdata_q[2*LinkW-1:LinkW];
          p_q     <= NIL;
          steps_q <= '0;
          state_q <= S_WALK;
        end
        S_WALK: begin
          state_q <= walk_ok ? S_CMP : S_DECIDE;
        end
        S_CMP: begin
          if (key_rdata_q == op_q.key) begin
            found_q <= 1'b1;
            slot_q  <= n_q;
            prev_q  <= p_q;
            nx_q    <= nxt_rdata_q;
            if (op_q.func == FUNC_LOOKUP) begin
              fval_q <= val_rdata_q;
            end
            state_q <= S_DECIDE;
          end else begin
            p_q     <= n_q;
            n_q     <= nxt_rdata_q;
            steps_q <= steps_q + LinkW'(1);
            state_q <= S_WALK;
          end
        end
        S_DECIDE: begin
          resp_q  <= 1'b1;
          state_q <= S_MV_COPY_RESP;
          case (op_q.func)
            FUNC_INSERT: begin
              if (!found_q) begin
                if (count_q >= LinkW'(CAPACITY)) begin
                  drop_q <= 1'b1;
                end else begin
                  count_q <= count_q + LinkW'(1);
                  slot_q  <= count_q;
                  if (tail_ok) begin
                    resp_q  <= 1'b0;
                    state_q <= S_INS_LINK;
                  end
                end
              end
            end
            FUNC_REMOVE: begin
              if (found_q) begin
                if (slot_q == last) begin
                  count_q <= last;
                end else begin
                  resp_q  <= 1'b0;
                  state_q <= S_MV_RD;
                end
              end
            end
            default: ;
          endcase
        end
        S_INS_LINK: begin
          resp_q  <= 1'b1;
          state_q <= S_MV_COPY_RESP;
        end
        S_MV_RD: state_q <= S_MV_CAP;
        S_MV_CAP: begin
          lkey_q  <= key_rdata_q;
          lval_q  <= val_rdata_q;
          lnext_q <= nxt_rdata_q;
          lb_q    <= (bid_rdata_q >= BktW'(BUCKETS)) ? (bid_rdata_q - BktW'(BUCKETS))
                                                     : bid_rdata_q;
          state_q <= S_MV_BRD;
        end
        S_MV_BRD: state_q <= S_MV_BCAP;
        S_MV_BCAP: begin
          head_q   <= bkt_rdata_q[2*LinkW-1:LinkW];
          tail_q   <= bkt_rdata_q[LinkW-1:0];
          n_q      <= bkt_rdata_q[2*LinkW-1:LinkW];
          p_q      <= NIL;
          steps_q  <= '0;
          fs_hit_q <= 1'b0;
          state_q  <= S_FS_WALK;
        end
        S_FS_WALK: begin
          if (walk_ok) begin
            if (n_q == last) begin
              fs_hit_q <= 1'b1;
              state_q  <= S_MV_FIX;
            end else begin
              state_q <= S_FS_NEXT;
            end
          end else begin
            state_q <= S_MV_FIX;
          end
        end
        S_FS_NEXT: begin
          p_q     <= n_q;
          n_q     <= nxt_rdata_q;
          steps_q <= steps_q + LinkW'(1);
          state_q <= S_FS_WALK;
        end
        S_MV_FIX: state_q <= S_MV_COPY_RESP;
        S_MV_COPY_RESP: begin
          if (!resp_q) begin
            // entry copy cycle, then present the result
            count_q <= last;
            resp_q  <= 1'b1;
          end else if (res_ready_i) begin
            resp_q   <= 1'b0;
            clr_op_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
